[src/dq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg - shared types for the double-ended queue
// Opcodes, status codes, controller states and the command/status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int OP_W    = 3;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;
	localparam int STAT_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_DUMP       = 3'd4
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_POP_WAIT,
		S_DUMP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    op_ld;        // capture the accepted transfer
		logic    push_do;      // write entry, move head/count
		logic    pop_do;       // read entry, move head/count
		logic    dump_rd;      // read next entry of a dump
		logic    dump_first;   // restart the dump pointer
		logic    out_ld;       // load the output register
		logic    out_from_mem; // output value from read data, else zero
		status_t out_status;
		logic    out_last;
	} dq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		opcode_t op;
		logic    empty;
		logic    full;
		logic    dump_last;
		logic    out_free;
	} dq_stat_t;

endpackage

[src/dq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl - deque sequencer
// Takes one operation at a time and steps the datapath through push, pop
// (with its memory read) and the entry-by-entry dump.
// ----------------------------------------------------------------------------
module dq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_valid,
	output logic             s_ready,
	input  dq_pkg::dq_stat_t stat,
	output dq_pkg::dq_cmd_t  cmd
);

	dq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dq_pkg::S_IDLE: begin
				if (s_valid) state_d = dq_pkg::S_EXEC;
			end
			dq_pkg::S_EXEC: begin
				unique case (stat.op) inside
					dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_REAR: begin
						if (stat.out_free) state_d = dq_pkg::S_IDLE;
					end
					dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_REAR: begin
						if (!stat.empty) state_d = dq_pkg::S_POP_WAIT;
						else if (stat.out_free) state_d = dq_pkg::S_IDLE;
					end
					dq_pkg::OP_DUMP: begin
						if (!stat.empty) state_d = dq_pkg::S_DUMP;
						else if (stat.out_free) state_d = dq_pkg::S_IDLE;
					end
					default: state_d = dq_pkg::S_IDLE; // undefined opcode: dropped
				endcase
			end
			dq_pkg::S_POP_WAIT: begin
				if (stat.out_free) state_d = dq_pkg::S_IDLE;
			end
			dq_pkg::S_DUMP: begin
				if (stat.out_free && stat.dump_last) state_d = dq_pkg::S_IDLE;
			end
			default: state_d = dq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.out_status = dq_pkg::ST_OK;
		s_ready        = 1'b0;
		unique case (state_q)
			dq_pkg::S_IDLE: begin
				s_ready    = 1'b1;
				cmd.op_ld  = s_valid;
			end
			dq_pkg::S_EXEC: begin
				unique case (stat.op) inside
					dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_REAR: begin
						if (stat.out_free) begin
							cmd.out_ld   = 1'b1;
							cmd.out_last = 1'b1;
							if (stat.full) begin
								cmd.out_status = dq_pkg::ST_FULL;
							end else begin
								cmd.push_do = 1'b1;
							end
						end
					end
					dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_REAR: begin
						if (!stat.empty) begin
							cmd.pop_do = 1'b1;
						end else if (stat.out_free) begin
							cmd.out_ld     = 1'b1;
							cmd.out_last   = 1'b1;
							cmd.out_status = dq_pkg::ST_EMPTY;
						end
					end
					dq_pkg::OP_DUMP: begin
						if (!stat.empty) begin
							cmd.dump_rd    = 1'b1;
							cmd.dump_first = 1'b1;
						end else if (stat.out_free) begin
							cmd.out_ld     = 1'b1;
							cmd.out_last   = 1'b1;
							cmd.out_status = dq_pkg::ST_EMPTY;
						end
					end
					default: ;
				endcase
			end
			dq_pkg::S_POP_WAIT: begin
				if (stat.out_free) begin
					cmd.out_ld       = 1'b1;
					cmd.out_from_mem = 1'b1;
					cmd.out_last     = 1'b1;
				end
			end
			dq_pkg::S_DUMP: begin
				if (stat.out_free) begin
					cmd.out_ld       = 1'b1;
					cmd.out_from_mem = 1'b1;
					cmd.out_last     = stat.dump_last;
					cmd.dump_rd      = !stat.dump_last;
				end
			end
			default: ;
		endcase
	end

endmodule

[src/dq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_datapath - ring storage, head/count registers and output register
// One write port and one registered read port on the entry memory; ring
// positions wrap with a single compare and subtract.
// ----------------------------------------------------------------------------
module dq_datapath #(
	parameter int CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dq_pkg::opcode_t               in_op,
	input  logic [dq_pkg::VALUE_W-1:0]    in_value,
	input  dq_pkg::dq_cmd_t               cmd,
	output dq_pkg::dq_stat_t              stat,
	input  logic                          m_ready,
	output logic                          out_valid,
	output logic [dq_pkg::VALUE_W-1:0]    out_value,
	output logic [dq_pkg::COUNT_W-1:0]    out_count,
	output dq_pkg::status_t               out_status,
	output logic                          out_last
);

	localparam int            IW      = $clog2(CAPACITY);
	localparam logic [IW:0]   CapExt  = (IW+1)'(CAPACITY);
	localparam logic [IW-1:0] IdxLast = IW'(CAPACITY - 1);
	localparam logic [dq_pkg::COUNT_W-1:0] CntFull = dq_pkg::COUNT_W'(CAPACITY);

	function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] base,
	                                           input logic [IW-1:0] off);
		logic [IW:0] sum;
		logic [IW:0] wrapped;
		sum     = {1'b0, base} + {1'b0, off};
		wrapped = sum - CapExt;
		if (sum >= CapExt) return wrapped[IW-1:0];
		return sum[IW-1:0];
	endfunction

	dq_pkg::opcode_t              op_q;
	logic [dq_pkg::VALUE_W-1:0]   val_q;
	logic [IW-1:0]                head_q, head_d;
	logic [dq_pkg::COUNT_W-1:0]   count_q, count_d, count_m1;
	logic [IW-1:0]                ptr_q, ptr_d;

	logic [dq_pkg::VALUE_W-1:0]   mem_q [CAPACITY];
	logic [dq_pkg::VALUE_W-1:0]   rd_data_q;
	logic                         wr_en, rd_en;
	logic [IW-1:0]                wr_addr, rd_addr;

	logic                         out_valid_q;
	logic [dq_pkg::VALUE_W-1:0]   out_value_q;
	logic [dq_pkg::COUNT_W-1:0]   out_count_q;
	dq_pkg::status_t              out_status_q;
	logic                         out_last_q;

	assign count_m1 = count_q - 1'b1;

	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		ptr_d   = ptr_q;
		wr_en   = 1'b0;
		wr_addr = '0;
		rd_en   = 1'b0;
		rd_addr = '0;
		if (cmd.push_do) begin
			wr_en   = 1'b1;
			count_d = count_q + 1'b1;
			if (op_q == dq_pkg::OP_PUSH_FRONT) begin
				head_d  = (head_q == '0) ? IdxLast : head_q - 1'b1;
				wr_addr = head_d;
			end else begin
				wr_addr = ring_pos(head_q, count_q[IW-1:0]);
			end
		end
		if (cmd.pop_do) begin
			rd_en   = 1'b1;
			count_d = count_m1;
			if (op_q == dq_pkg::OP_POP_FRONT) begin
				rd_addr = head_q;
				head_d  = ring_pos(head_q, IW'(1));
			end else begin
				rd_addr = ring_pos(head_q, count_m1[IW-1:0]);
			end
		end
		if (cmd.dump_rd) begin
			rd_en   = 1'b1;
			ptr_d   = cmd.dump_first ? '0 : ptr_q + 1'b1;
			rd_addr = ring_pos(head_q, ptr_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op_ld) begin
			op_q  <= in_op;
			val_q <= in_value;
		end
		ptr_q <= ptr_d;
	end

	// entry memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= val_q;
		if (rd_en) rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (m_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_value_q  <= cmd.out_from_mem ? rd_data_q : '0;
			out_count_q  <= count_d;
			out_status_q <= cmd.out_status;
			out_last_q   <= cmd.out_last;
		end
	end

	assign stat.op        = op_q;
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q == CntFull);
	assign stat.dump_last = ((dq_pkg::COUNT_W'(ptr_q) + 1'b1) == count_q);
	assign stat.out_free  = !out_valid_q || m_ready;

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_count  = out_count_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntFull)
		else $error("entry count beyond capacity");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, head_q} < CapExt)
		else $error("head index outside ring");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_do |-> !stat.full)
		else $error("push executed on full queue");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop_do || cmd.dump_rd) |-> !stat.empty)
		else $error("read issued on empty queue");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> stat.out_free)
		else $error("pending result overwritten");

endmodule

[src/double_ended_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top - double-ended queue of signed 32-bit values
// Ring buffer with push/pop at either end and a front-to-rear dump.
//
//  channel   dir  tdata                                   tuser        tlast
//  s_axis    in   [2:0] opcode, [34:3] push_value         -            -
//  m_axis    out  [31:0] item_value, [38:32] entry_count  [1:0] status last_of_run
//
//  Push or refused/empty op: the op is captured, then its result registered.
//  Pop: op captured, memory read registered, then result. Dump: one result
//  per entry, one per cycle while not stalled, paced by the single read port.
//  One operation at a time; the next transfer in is taken once the block is
//  back in idle, while a finished result may still sit in the output register.
//  Reset clears the sequencer, head, count and output valid; the entry memory
//  needs no clearing.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [2:0] opcode, [34:3] push_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] item_value, [38:32] entry_count
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast
);

	dq_pkg::dq_cmd_t               cmd;
	dq_pkg::dq_stat_t              stat;
	logic [dq_pkg::VALUE_W-1:0]    out_value;
	logic [dq_pkg::COUNT_W-1:0]    out_count;
	dq_pkg::status_t               out_status;

	dq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.s_ready (s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	dq_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_op      (dq_pkg::opcode_t'(s_tdata[2:0])),
		.in_value   (s_tdata[34:3]),
		.cmd        (cmd),
		.stat       (stat),
		.m_ready    (m_tready),
		.out_valid  (m_tvalid),
		.out_value  (out_value),
		.out_count  (out_count),
		.out_status (out_status),
		.out_last   (m_tlast)
	);

	assign m_tdata = {1'b0, out_count, out_value};
	assign m_tuser = out_status;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for double_ended_queue_top
// Operations are streamed in from a queue built at time zero, with random
// gaps on the input and random stalls on the output. Each accepted
// operation runs through a behavioural deque, and each result transfer is
// compared with the oldest result still owed.
// ----------------------------------------------------------------------------
module testbench;

	localparam int     DQ_CAP      = 64;
	localparam int     CODE_MAX    = (1 << dq_pkg::OP_W) - 1;
	localparam int     RANDOM_OPS  = 310;
	localparam int     SETTLE_CYC  = 50;
	localparam longint LIMIT_NS    = 64'd100_000_000;

	typedef struct {
		logic [dq_pkg::OP_W-1:0]    code;
		logic [dq_pkg::VALUE_W-1:0] value;
		bit                         hold;   // wait for every owed result before sending
	} op_item_t;

	typedef struct {
		logic [dq_pkg::VALUE_W-1:0] value;
		logic [dq_pkg::COUNT_W-1:0] count;
		dq_pkg::status_t            status;
		logic                       last;
	} deque_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	op_item_t      pending_ops[$];
	deque_result_t results_due[$];

	// behavioural copy of the ring
	logic [dq_pkg::VALUE_W-1:0] ring_mem[DQ_CAP];
	int ring_head  = 0;
	int ring_count = 0;

	bit in_fire   = 1'b0;
	bit out_fire  = 1'b0;
	bit in_burst  = 1'b0;
	bit out_burst = 1'b0;
	int in_gap    = 0;
	int out_stall = 0;

	int n_valid_queued = 0;
	int n_accepted     = 0;
	int n_ignored      = 0;
	int n_dumps        = 0;
	int n_refused      = 0;
	int n_empty        = 0;
	int n_checked      = 0;
	int n_mismatch     = 0;

	double_ended_queue_top #(
		.CAPACITY (DQ_CAP)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	function automatic int pick_gap(input bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [dq_pkg::VALUE_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_op(input logic [dq_pkg::OP_W-1:0] code,
			input logic [dq_pkg::VALUE_W-1:0] value, input bit hold);
		op_item_t it;
		it.code  = code;
		it.value = value;
		it.hold  = hold;
		pending_ops.push_back(it);
		if (code <= dq_pkg::OP_DUMP)
			n_valid_queued++;
	endtask

	// Applies one operation to the behavioural deque and owes its results.
	task automatic advance_deque(input logic [dq_pkg::OP_W-1:0] code,
			input logic [dq_pkg::VALUE_W-1:0] value);
		deque_result_t r;
		int slot;
		int i;
		r.value  = '0;
		r.status = dq_pkg::ST_OK;
		r.last   = 1'b1;
		case (code) inside
			dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_REAR: begin
				if (ring_count == DQ_CAP) begin
					r.status = dq_pkg::ST_FULL;
					n_refused++;
				end else begin
					if (code == dq_pkg::OP_PUSH_FRONT) begin
						ring_head = (ring_head + DQ_CAP - 1) % DQ_CAP;
						slot = ring_head;
					end else begin
						slot = (ring_head + ring_count) % DQ_CAP;
					end
					ring_mem[slot] = value;
					ring_count++;
				end
				r.count = 7'(ring_count);
				results_due.push_back(r);
			end
			dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_REAR: begin
				if (ring_count == 0) begin
					r.status = dq_pkg::ST_EMPTY;
					n_empty++;
				end else begin
					if (code == dq_pkg::OP_POP_FRONT) begin
						slot = ring_head;
						ring_head = (ring_head + 1) % DQ_CAP;
					end else begin
						slot = (ring_head + ring_count - 1) % DQ_CAP;
					end
					r.value = ring_mem[slot];
					ring_count--;
				end
				r.count = 7'(ring_count);
				results_due.push_back(r);
			end
			dq_pkg::OP_DUMP: begin
				n_dumps++;
				r.count = 7'(ring_count);
				if (ring_count == 0) begin
					r.status = dq_pkg::ST_EMPTY;
					n_empty++;
					results_due.push_back(r);
				end else begin
					for (i = 0; i < ring_count; i++) begin
						r.value = ring_mem[(ring_head + i) % DQ_CAP];
						r.last  = (i == ring_count - 1);
						results_due.push_back(r);
					end
				end
			end
			default: n_ignored++;
		endcase
	endtask

	// input side: new transfer presented at the falling edge
	always @(negedge clk or negedge arst_n) begin : drive_in
		logic        nv;
		logic [39:0] nd;
		int          gap;
		op_item_t    it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			in_gap   <= 0;
		end else begin
			nv  = s_tvalid;
			nd  = s_tdata;
			gap = in_gap;
			if (!s_tvalid || in_fire) begin
				nv = 1'b0;
				if (in_fire)
					gap = pick_gap(in_burst);
				if (gap > 0) begin
					gap--;
				end else if (pending_ops.size() > 0 &&
						!(pending_ops[0].hold && results_due.size() > 0)) begin
					it = pending_ops.pop_front();
					nv = 1'b1;
					nd = {5'b0, it.value, it.code};
					if ($urandom_range(0, 49) == 0)
						in_burst = ~in_burst;
				end
			end
			s_tvalid <= nv;
			s_tdata  <= nd;
			in_gap   <= gap;
		end
	end

	// output side: back-pressure after transfers and now and then at random
	always @(negedge clk or negedge arst_n) begin : drive_out
		int st;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			out_stall <= 0;
		end else begin
			st = out_stall;
			if (out_fire || (st == 0 && $urandom_range(0, 19) == 0)) begin
				st = pick_gap(out_burst);
				if ($urandom_range(0, 49) == 0)
					out_burst = ~out_burst;
			end
			if (st > 0) begin
				m_tready <= 1'b0;
				st--;
			end else begin
				m_tready <= 1'b1;
			end
			out_stall <= st;
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		deque_result_t want;
		if (!arst_n) begin
			in_fire  <= 1'b0;
			out_fire <= 1'b0;
		end else begin
			in_fire  <= s_tvalid && s_tready;
			out_fire <= m_tvalid && m_tready;
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					if (n_mismatch < 10)
						$display("%t unexpected result: value %h count %0d status %0d last %b",
							$realtime, m_tdata[31:0], m_tdata[38:32], m_tuser, m_tlast);
					n_mismatch++;
				end else begin
					want = results_due.pop_front();
					n_checked++;
					if (m_tdata[31:0] !== want.value || m_tdata[38:32] !== want.count ||
							m_tuser !== want.status || m_tlast !== want.last) begin
						if (n_mismatch < 10) begin
							$display("%t result mismatch (expected/actual):", $realtime);
							$display("    value %h/%h count %0d/%0d status %0d/%0d last %b/%b",
								want.value, m_tdata[31:0], want.count, m_tdata[38:32],
								want.status, m_tuser, want.last, m_tlast);
						end
						n_mismatch++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				n_accepted++;
				advance_deque(s_tdata[dq_pkg::OP_W-1:0],
					s_tdata[dq_pkg::OP_W+dq_pkg::VALUE_W-1:dq_pkg::OP_W]);
			end
		end
	end

	initial begin : stimulus
		int seg_len;
		int bias;
		int r;
		int i;
		int j;

		// directed: empty cases, value extremes, every operation, unused codes
		queue_op(dq_pkg::OP_DUMP,       pick_word(),   1'b0);
		queue_op(dq_pkg::OP_POP_FRONT,  pick_word(),   1'b0);
		queue_op(dq_pkg::OP_POP_REAR,   pick_word(),   1'b0);
		queue_op(dq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 1'b0);
		queue_op(dq_pkg::OP_PUSH_REAR,  32'h7FFF_FFFF, 1'b0);
		queue_op(dq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0);
		queue_op(dq_pkg::OP_PUSH_REAR,  32'h0000_0000, 1'b0);
		queue_op(dq_pkg::OP_DUMP,       pick_word(),   1'b0);
		for (i = 1; i <= CODE_MAX - dq_pkg::OP_DUMP; i++)
			queue_op(3'(dq_pkg::OP_DUMP + i), pick_word(), 1'b0);
		queue_op(dq_pkg::OP_POP_FRONT,  pick_word(),   1'b0);
		queue_op(dq_pkg::OP_POP_REAR,   pick_word(),   1'b0);
		queue_op(dq_pkg::OP_PUSH_REAR,  32'h5555_5555, 1'b0);
		queue_op(dq_pkg::OP_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0);
		queue_op(dq_pkg::OP_DUMP,       pick_word(),   1'b0);
		queue_op(dq_pkg::OP_POP_REAR,   pick_word(),   1'b0);
		queue_op(dq_pkg::OP_POP_FRONT,  pick_word(),   1'b0);
		queue_op(dq_pkg::OP_POP_REAR,   pick_word(),   1'b0);
		queue_op(dq_pkg::OP_POP_FRONT,  pick_word(),   1'b0);
		queue_op(dq_pkg::OP_POP_FRONT,  pick_word(),   1'b0);
		queue_op(dq_pkg::OP_DUMP,       pick_word(),   1'b0);

		// fill past capacity, dump the full ring, then drain past empty
		for (i = 0; i < DQ_CAP + 2; i++)
			queue_op($urandom_range(0, 1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_REAR,
				pick_word(), i == 0);
		queue_op(dq_pkg::OP_DUMP, pick_word(), 1'b0);
		for (i = 0; i < DQ_CAP + 2; i++)
			queue_op($urandom_range(0, 1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_REAR,
				pick_word(), 1'b0);

		// segments leaning towards growth, shrinkage or balance
		j = 0;
		while (n_valid_queued < RANDOM_OPS) begin
			seg_len = $urandom_range(8, 30);
			bias = $urandom_range(0, 2);
			for (i = 0; i < seg_len; i++) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					queue_op(3'($urandom_range(dq_pkg::OP_DUMP + 1, CODE_MAX)),
						pick_word(), 1'b0);
				else if (r < 10)
					queue_op(dq_pkg::OP_DUMP, pick_word(), j == 1);
				else if (r < (bias == 0 ? 75 : bias == 1 ? 30 : 54))
					queue_op($urandom_range(0, 1) ? dq_pkg::OP_PUSH_FRONT :
						dq_pkg::OP_PUSH_REAR, pick_word(), j == 1);
				else
					queue_op($urandom_range(0, 1) ? dq_pkg::OP_POP_FRONT :
						dq_pkg::OP_POP_REAR, pick_word(), j == 1);
				j++;
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_ops.size() != 0 || s_tvalid)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		@(negedge clk);

		$display("tb: %0d operations taken (%0d dumps, %0d unused codes), %0d results checked",
			n_accepted, n_dumps, n_ignored, n_checked);
		$display("tb: %0d pushes refused when full, %0d pops or dumps when empty, %0d mismatches",
			n_refused, n_empty, n_mismatch);
		if (n_mismatch == 0 && results_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#(LIMIT_NS);
		$display("tb: run timed out with %0d results outstanding", results_due.size());
		$display("tb: failure");
		$finish;
	end

endmodule

[files.f]
src/dq_pkg.sv
src/dq_ctrl.sv
src/dq_datapath.sv
src/double_ended_queue_top.sv
dv/testbench.sv
